[sv/mtsd_pkg.sv]
package mtsd_pkg;

    localparam int NUM_SLOTS_DEF = 16;

    localparam int TYPE_W = 16;
    localparam int CODE_W = 16;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 4;
    localparam int KIND_W = 2;

    localparam logic [TYPE_W-1:0] EV_SYN = 16'h0000;
    localparam logic [TYPE_W-1:0] EV_ABS = 16'h0003;

    localparam logic [CODE_W-1:0] CODE_SYNC_RPT = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_SLOT_SEL = 16'h002f;
    localparam logic [CODE_W-1:0] CODE_POS_X    = 16'h0035;
    localparam logic [CODE_W-1:0] CODE_POS_Y    = 16'h0036;
    localparam logic [CODE_W-1:0] CODE_TRACK_ID = 16'h0039;
    localparam logic [CODE_W-1:0] CODE_PRESSURE = 16'h003a;

    localparam logic [VAL_W-1:0] LIFT_ID = 32'hFFFF_FFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_MOVE = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                   kind;
        logic signed [VAL_W-1:0] tracking_id;
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pressure;
    } t_slot;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODIFY,
        S_SCAN,
        S_RDWAIT
    } t_state;

endpackage

[sv/mtsd_event_if.sv]
interface mtsd_event_if;
    logic                                 valid;
    logic                                 ready;
    logic        [mtsd_pkg::TYPE_W-1:0]   event_type;
    logic        [mtsd_pkg::CODE_W-1:0]   event_code;
    logic signed [mtsd_pkg::VAL_W-1:0]    event_value;

    modport source (output valid, event_type, event_code, event_value, input ready);
    modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

[sv/mtsd_slot_if.sv]
interface mtsd_slot_if;
    logic                                 valid;
    logic                                 ready;
    logic        [mtsd_pkg::IDX_W-1:0]    slot_index;
    logic        [mtsd_pkg::KIND_W-1:0]   contact_kind;
    logic signed [mtsd_pkg::VAL_W-1:0]    tracking_id;
    logic signed [mtsd_pkg::VAL_W-1:0]    pos_x;
    logic signed [mtsd_pkg::VAL_W-1:0]    pos_y;
    logic signed [mtsd_pkg::VAL_W-1:0]    contact_pressure;
    logic                                 last_of_report;

    modport source (output valid, slot_index, contact_kind, tracking_id, pos_x, pos_y,
                    contact_pressure, last_of_report, input ready);
    modport sink   (input valid, slot_index, contact_kind, tracking_id, pos_x, pos_y,
                    contact_pressure, last_of_report, output ready);
endinterface

[sv/mtsd_ram.sv]
module mtsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/multitouch_slot_event_decoder.sv]
// Channel   Dir   Role    Payload
// i_ev      in    sink    event_type, event_code, event_value
// o_slot    out   source  slot_index, contact_kind, tracking_id, pos_x, pos_y,
//                         contact_pressure, last_of_report
//
// An event other than a sync report reads its slot table entry while idle, then writes
// it back in S_MODIFY. A sync report with no changed slot is taken without leaving idle;
// otherwise it walks the slot table from index 0, one unchanged index per cycle, and on
// each changed slot reads the entry (S_SCAN), then emits it and writes it back (S_RDWAIT).
// Reset clears the pointer, the changed mask and one valid bit per slot; a slot never
// written reads as all zero. A stalled output holds the walk before the next table read.
module multitouch_slot_event_decoder #(
    parameter int NUM_SLOTS = mtsd_pkg::NUM_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mtsd_event_if.sink          i_ev,
    mtsd_slot_if.source         o_slot
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EW = $bits(mtsd_pkg::t_slot);

    mtsd_pkg::t_state              r_state, n_state;
    logic [SW-1:0]                 r_cur, n_cur;
    logic [SW-1:0]                 r_scan, n_scan;
    logic [NUM_SLOTS-1:0]          r_mask, n_mask;
    logic [NUM_SLOTS-1:0]          r_vld;
    logic                          r_rd_vld;

    logic [SW-1:0]                 r_addr;
    logic                          r_is_abs;
    logic [mtsd_pkg::CODE_W-1:0]   r_code;
    logic [mtsd_pkg::VAL_W-1:0]    r_value;

    logic                          r_out_valid;
    logic [mtsd_pkg::IDX_W-1:0]    r_out_idx;
    mtsd_pkg::t_slot               r_out_slot;
    logic                          r_out_last;

    logic                          w_acc;
    logic                          w_sync;
    logic                          w_sel;
    logic [SW-1:0]                 w_cur;
    logic                          n_load;
    logic                          n_last;

    logic                          ram_we;
    logic [SW-1:0]                 ram_waddr;
    logic [SW-1:0]                 ram_raddr;
    mtsd_pkg::t_slot               ram_wdata;
    logic [EW-1:0]                 ram_rdata;
    mtsd_pkg::t_slot               rd_slot;

    mtsd_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_ev.ready = (r_state == mtsd_pkg::S_IDLE);
    assign w_acc      = i_ev.valid && i_ev.ready;
    assign w_sync     = (i_ev.event_type == mtsd_pkg::EV_SYN)
                        && (i_ev.event_code == mtsd_pkg::CODE_SYNC_RPT);
    assign w_sel      = (i_ev.event_type == mtsd_pkg::EV_ABS)
                        && (i_ev.event_code == mtsd_pkg::CODE_SLOT_SEL)
                        && (unsigned'(i_ev.event_value) < 32'(NUM_SLOTS));
    assign w_cur      = w_sel ? i_ev.event_value[SW-1:0] : r_cur;

    // an entry never written reads as all zero
    assign rd_slot = r_rd_vld ? mtsd_pkg::t_slot'(ram_rdata) : '0;

    always_comb begin
        n_state   = r_state;
        n_cur     = r_cur;
        n_scan    = r_scan;
        n_mask    = r_mask;
        n_load    = 1'b0;
        n_last    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_raddr = r_scan;
        ram_wdata = rd_slot;
        unique case (r_state)
            mtsd_pkg::S_IDLE: begin
                ram_raddr = w_cur;
                if (w_acc) begin
                    if (w_sync) begin
                        if (r_mask != '0) begin
                            n_scan  = '0;
                            n_state = mtsd_pkg::S_SCAN;
                        end
                    end else begin
                        n_cur   = w_cur;
                        n_mask  = r_mask | (NUM_SLOTS'(1) << w_cur);
                        n_state = mtsd_pkg::S_MODIFY;
                    end
                end
            end
            mtsd_pkg::S_MODIFY: begin
                ram_we = 1'b1;
                if (r_is_abs) begin
                    case (r_code)
                        mtsd_pkg::CODE_TRACK_ID: begin
                            if (r_value == mtsd_pkg::LIFT_ID) begin
                                ram_wdata.kind = mtsd_pkg::KIND_UP;
                            end else begin
                                ram_wdata.kind        = mtsd_pkg::KIND_DOWN;
                                ram_wdata.tracking_id = r_value;
                            end
                        end
                        mtsd_pkg::CODE_POS_X:    ram_wdata.pos_x    = r_value;
                        mtsd_pkg::CODE_POS_Y:    ram_wdata.pos_y    = r_value;
                        mtsd_pkg::CODE_PRESSURE: ram_wdata.pressure = r_value;
                        default: begin
                        end
                    endcase
                end
                n_state = mtsd_pkg::S_IDLE;
            end
            mtsd_pkg::S_SCAN: begin
                // read only once the output register is sure to be free next cycle
                if (r_mask[r_scan]) begin
                    if (!r_out_valid || o_slot.ready) begin
                        n_state = mtsd_pkg::S_RDWAIT;
                    end
                end else begin
                    n_scan = r_scan + SW'(1);
                end
            end
            mtsd_pkg::S_RDWAIT: begin
                n_load         = 1'b1;
                ram_we         = 1'b1;
                ram_waddr      = r_scan;
                ram_wdata.kind = mtsd_pkg::KIND_MOVE;
                n_mask         = r_mask & ~(NUM_SLOTS'(1) << r_scan);
                n_last         = (n_mask == '0);
                n_scan         = r_scan + SW'(1);
                n_state        = n_last ? mtsd_pkg::S_IDLE : mtsd_pkg::S_SCAN;
            end
            default: begin
                n_state = mtsd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtsd_pkg::S_IDLE;
            r_cur   <= '0;
            r_scan  <= '0;
            r_mask  <= '0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_scan  <= n_scan;
            r_mask  <= n_mask;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[ram_raddr];
        if (w_acc) begin
            r_addr   <= w_cur;
            r_is_abs <= (i_ev.event_type == mtsd_pkg::EV_ABS);
            r_code   <= i_ev.event_code;
            r_value  <= i_ev.event_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_load) begin
            r_out_valid <= 1'b1;
        end else if (o_slot.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_idx  <= mtsd_pkg::IDX_W'(r_scan);
            r_out_slot <= rd_slot;
            r_out_last <= n_last;
        end
    end

    assign o_slot.valid            = r_out_valid;
    assign o_slot.slot_index       = r_out_idx;
    assign o_slot.contact_kind     = r_out_slot.kind;
    assign o_slot.tracking_id      = r_out_slot.tracking_id;
    assign o_slot.pos_x            = r_out_slot.pos_x;
    assign o_slot.pos_y            = r_out_slot.pos_y;
    assign o_slot.contact_pressure = r_out_slot.pressure;
    assign o_slot.last_of_report   = r_out_last;

    a_scan_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtsd_pkg::S_SCAN) |-> (r_mask != '0))
        else $error("slot walk running with an empty changed mask");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtsd_pkg::S_IDLE) |-> !ram_we)
        else $error("slot table written while idle");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_load |-> (!r_out_valid || o_slot.ready))
        else $error("output register overwritten before it was taken");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_load && n_last) |=> ((r_mask == '0) && (r_state == mtsd_pkg::S_IDLE)))
        else $error("last slot of report emitted with changed slots left");

endmodule
